>>> design/ntprod_pkg.sv
// shared types, constants and helpers for the sntp offset and delay block
package ntprod_pkg;

    localparam int PACKET_BYTES_DEF = 48;

    localparam int OFF_ORIGINATE = 24;
    localparam int OFF_RECEIVE   = 32;
    localparam int OFF_TRANSMIT  = 40;
    localparam int STAMP_BYTES   = 8;

    localparam int EPOCH_W = 63;
    localparam int TPM_W   = 20;
    localparam int MS_W    = 42;
    localparam int TICK_W  = 64;

    localparam logic [MS_W-1:0]    MS_PER_S    = 42'd1000;
    localparam logic [2:0]         MODE_SERVER = 3'd4;
    localparam logic [EPOCH_W-1:0] EPOCH_RESET = 63'd94354848000000000;
    localparam logic [TPM_W-1:0]   TPM_RESET   = 20'd10000;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_MODE  = 2'd1;
    localparam logic [1:0] STAT_SHORT = 2'd2;

    localparam logic CFG_EPOCH = 1'b0;
    localparam logic CFG_TPM   = 1'b1;

    localparam logic [1:0] SEL_ORIG = 2'd0;
    localparam logic [1:0] SEL_RECV = 2'd1;
    localparam logic [1:0] SEL_XMIT = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MS,
        OP_MUL,
        OP_ADD,
        OP_DIFF,
        OP_COMB,
        OP_HALF,
        OP_LOAD
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] sel;
        logic       take_byte;
        logic       take_last;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MS,
        ST_MUL,
        ST_ADD,
        ST_DIFF,
        ST_COMB,
        ST_HALF,
        ST_DONE
    } t_state;

    function automatic logic [1:0] f_stratum_class(input logic [7:0] s);
        logic [1:0] c;
        if (s == 8'd0) begin
            c = 2'd0;
        end else if (s == 8'd1) begin
            c = 2'd1;
        end else if (s <= 8'd15) begin
            c = 2'd2;
        end else begin
            c = 2'd3;
        end
        return c;
    endfunction

endpackage

>>> design/ntprod_ctrl.sv
// controller: byte intake, conversion sequence and output handshake
module ntprod_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_last_byte,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output ntprod_pkg::t_cmd  o_cmd
);

    ntprod_pkg::t_state r_state, n_state;
    logic [1:0]         r_sel, n_sel;
    logic               r_out_valid, n_out_valid;
    logic               w_accept;

    assign o_in_ready  = (r_state == ntprod_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ntprod_pkg::ST_IDLE;
            r_sel       <= ntprod_pkg::SEL_ORIG;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_sel            = r_sel;
        n_out_valid      = r_out_valid;
        o_cmd.op         = ntprod_pkg::OP_NONE;
        o_cmd.sel        = r_sel;
        o_cmd.take_byte  = w_accept;
        o_cmd.take_last  = w_accept && i_last_byte;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ntprod_pkg::ST_IDLE: begin
                if (w_accept && i_last_byte) begin
                    n_state = ntprod_pkg::ST_MS;
                    n_sel   = ntprod_pkg::SEL_ORIG;
                end
            end
            ntprod_pkg::ST_MS: begin
                o_cmd.op = ntprod_pkg::OP_MS;
                n_state  = ntprod_pkg::ST_MUL;
            end
            ntprod_pkg::ST_MUL: begin
                o_cmd.op = ntprod_pkg::OP_MUL;
                n_state  = ntprod_pkg::ST_ADD;
            end
            ntprod_pkg::ST_ADD: begin
                o_cmd.op = ntprod_pkg::OP_ADD;
                if (r_sel == ntprod_pkg::SEL_XMIT) begin
                    n_state = ntprod_pkg::ST_DIFF;
                end else begin
                    n_sel   = r_sel + 2'd1;
                    n_state = ntprod_pkg::ST_MS;
                end
            end
            ntprod_pkg::ST_DIFF: begin
                o_cmd.op = ntprod_pkg::OP_DIFF;
                n_state  = ntprod_pkg::ST_COMB;
            end
            ntprod_pkg::ST_COMB: begin
                o_cmd.op = ntprod_pkg::OP_COMB;
                n_state  = ntprod_pkg::ST_HALF;
            end
            ntprod_pkg::ST_HALF: begin
                o_cmd.op = ntprod_pkg::OP_HALF;
                n_state  = ntprod_pkg::ST_DONE;
            end
            ntprod_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = ntprod_pkg::OP_LOAD;
                    n_out_valid = 1'b1;
                    n_state     = ntprod_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ntprod_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_last_blocks_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last_byte) |=> !o_in_ready)
        else $error("intake still open after last item");

    a_sel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel != 2'd3)
        else $error("timestamp select out of range");

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ntprod_pkg::ST_DONE && r_out_valid && !i_out_ready)
        |=> (r_state == ntprod_pkg::ST_DONE))
        else $error("result overwritten while output stalled");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == ntprod_pkg::OP_LOAD) |=> o_out_valid)
        else $error("result loaded without valid");
`endif

endmodule

>>> design/ntprod_dp.sv
// datapath: packet capture, timestamp conversion, delay and offset
module ntprod_dp #(
    parameter int PACKET_BYTES = ntprod_pkg::PACKET_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ntprod_pkg::t_cmd                    i_cmd,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [ntprod_pkg::EPOCH_W-1:0]      i_cfg_data,
    input  logic [7:0]                          i_packet_byte,
    input  logic [ntprod_pkg::EPOCH_W-1:0]      i_arrival_ticks,
    output logic [1:0]                          o_status,
    output logic [1:0]                          o_leap,
    output logic [2:0]                          o_version,
    output logic [2:0]                          o_mode_code,
    output logic [1:0]                          o_stratum_class,
    output logic signed [ntprod_pkg::TICK_W-1:0] o_round_trip,
    output logic signed [ntprod_pkg::TICK_W-1:0] o_clock_offset
);

    localparam int CNT_W = $clog2(PACKET_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PACKET_BYTES);
    localparam logic [CNT_W-1:0] C_ORIG   = CNT_W'(ntprod_pkg::OFF_ORIGINATE);
    localparam logic [CNT_W-1:0] C_RECV   = CNT_W'(ntprod_pkg::OFF_RECEIVE);
    localparam logic [CNT_W-1:0] C_XMIT   = CNT_W'(ntprod_pkg::OFF_TRANSMIT);
    localparam logic [CNT_W-1:0] C_XEND   =
        CNT_W'(ntprod_pkg::OFF_TRANSMIT + ntprod_pkg::STAMP_BYTES);
    localparam int TW = ntprod_pkg::TICK_W;
    localparam int MW = ntprod_pkg::MS_W;

    logic [CNT_W-1:0]                 r_count, n_count, w_count_inc;
    logic [ntprod_pkg::EPOCH_W-1:0]   r_epoch;
    logic [ntprod_pkg::TPM_W-1:0]     r_tpm;
    logic [7:0]                       r_hdr0, r_hdr1;
    logic [TW-1:0]                    r_orig, r_recv, r_xmit;
    logic [ntprod_pkg::EPOCH_W-1:0]   r_arrival;
    logic                             r_short;
    logic [MW-1:0]                    r_ms;
    logic [TW-1:0]                    r_prod;
    logic [TW-1:0]                    r_tick [3];
    logic [TW-1:0]                    r_d1, r_d2, r_d3, r_d4;
    logic [TW-1:0]                    r_rt, r_sum;
    logic                             r_neg;
    logic [TW-2:0]                    r_mag;
    logic [1:0]                       r_status, r_leap, r_sc;
    logic [2:0]                       r_version, r_mode;
    logic [TW-1:0]                    r_out_rt, r_out_off;

    logic [TW-1:0]                    w_stamp, w_abs, w_off, w_arr;
    logic [MW-1:0]                    w_secs_ms, w_frac_ms, w_ms;
    logic [1:0]                       w_status;

    // saturating byte count
    always_comb begin
        w_count_inc = (r_count < CNT_FULL) ? r_count + CNT_W'(1) : r_count;
        n_count     = r_count;
        if (i_cmd.take_byte) begin
            n_count = i_cmd.take_last ? '0 : w_count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_epoch <= ntprod_pkg::EPOCH_RESET;
            r_tpm   <= ntprod_pkg::TPM_RESET;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ntprod_pkg::CFG_EPOCH: r_epoch <= i_cfg_data;
                    ntprod_pkg::CFG_TPM:   r_tpm   <= i_cfg_data[ntprod_pkg::TPM_W-1:0];
                    default:               r_epoch <= r_epoch;
                endcase
            end
        end
    end

    // packet capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && (r_count < CNT_FULL)) begin
            if (r_count == CNT_W'(0)) begin
                r_hdr0 <= i_packet_byte;
            end else if (r_count == CNT_W'(1)) begin
                r_hdr1 <= i_packet_byte;
            end else if (r_count >= C_ORIG && r_count < C_RECV) begin
                r_orig <= {r_orig[TW-9:0], i_packet_byte};
            end else if (r_count >= C_RECV && r_count < C_XMIT) begin
                r_recv <= {r_recv[TW-9:0], i_packet_byte};
            end else if (r_count >= C_XMIT && r_count < C_XEND) begin
                r_xmit <= {r_xmit[TW-9:0], i_packet_byte};
            end
        end
        if (i_cmd.take_last) begin
            r_arrival <= i_arrival_ticks;
            r_short   <= (w_count_inc < CNT_FULL);
        end
    end

    // shared timestamp conversion unit, plus arrival widening, offset sign handling and status
    always_comb begin
        case (i_cmd.sel)
            ntprod_pkg::SEL_ORIG: w_stamp = r_orig;
            ntprod_pkg::SEL_RECV: w_stamp = r_recv;
            default:              w_stamp = r_xmit;
        endcase
        w_secs_ms = MW'(w_stamp[63:32]) * ntprod_pkg::MS_PER_S;
        w_frac_ms = MW'(w_stamp[31:0]) * ntprod_pkg::MS_PER_S;
        w_ms      = w_secs_ms + MW'(w_frac_ms[MW-1:32]);
        w_arr     = {1'b0, r_arrival};
        w_abs     = r_sum[TW-1] ? (~r_sum + TW'(1)) : r_sum;
        w_off     = r_neg ? (~{1'b0, r_mag} + TW'(1)) : {1'b0, r_mag};
        if (r_short) begin
            w_status = ntprod_pkg::STAT_SHORT;
        end else if (r_hdr0[2:0] != ntprod_pkg::MODE_SERVER) begin
            w_status = ntprod_pkg::STAT_MODE;
        end else begin
            w_status = ntprod_pkg::STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ntprod_pkg::OP_MS: begin
                r_ms <= w_ms;
            end
            ntprod_pkg::OP_MUL: begin
                r_prod <= TW'(62'(r_ms) * 62'(r_tpm));
            end
            ntprod_pkg::OP_ADD: begin
                r_tick[i_cmd.sel] <= {1'b0, r_epoch} + r_prod;
            end
            ntprod_pkg::OP_DIFF: begin
                r_d1 <= w_arr - r_tick[0];
                r_d2 <= r_tick[2] - r_tick[1];
                r_d3 <= r_tick[1] - r_tick[0];
                r_d4 <= r_tick[2] - w_arr;
            end
            ntprod_pkg::OP_COMB: begin
                r_rt  <= r_d1 - r_d2;
                r_sum <= r_d3 + r_d4;
            end
            ntprod_pkg::OP_HALF: begin
                r_neg <= r_sum[TW-1];
                r_mag <= w_abs[TW-1:1];
            end
            ntprod_pkg::OP_LOAD: begin
                r_status  <= w_status;
                r_leap    <= r_short ? 2'd0 : r_hdr0[7:6];
                r_version <= r_short ? 3'd0 : r_hdr0[5:3];
                r_mode    <= r_short ? 3'd0 : r_hdr0[2:0];
                r_sc      <= r_short ? 2'd0 : ntprod_pkg::f_stratum_class(r_hdr1);
                r_out_rt  <= (w_status == ntprod_pkg::STAT_OK) ? r_rt : '0;
                r_out_off <= (w_status == ntprod_pkg::STAT_OK) ? w_off : '0;
            end
            default: begin
            end
        endcase
    end

    assign o_status        = r_status;
    assign o_leap          = r_leap;
    assign o_version       = r_version;
    assign o_mode_code     = r_mode;
    assign o_stratum_class = r_sc;
    assign o_round_trip    = $signed(r_out_rt);
    assign o_clock_offset  = $signed(r_out_off);

endmodule

>>> design/ntp_response_offset_delay_top.sv
// top level of the sntp response parser with clock offset and round-trip delay
//
// input channel: one packet byte per item, wire order, with a last flag; the
// item marked last also carries the local arrival time in ticks. non-last
// items are taken one per cycle while intake is open; bytes beyond the packet
// length are dropped until the last one.
// output channel: one result per packet (status, header fields, round-trip
// delay and clock offset), produced once the conversion sequence is done.
// the three timestamps share one conversion unit (ms, multiply and epoch add
// states, one timestamp after another), then the diff, comb and half states
// form the delay, the offset and its halving. intake is closed from the last
// item until the result is loaded, so a new packet is not taken before the
// last one is through; the next packet may stream in while a result still
// waits in the output register. if the receiver stalls, the finished result
// holds and the next result waits until the output register is free.
// after reset the byte count is zero, no result is pending and the
// configuration registers hold their defaults; write them only while idle.
module ntp_response_offset_delay_top #(
    parameter int PACKET_BYTES = ntprod_pkg::PACKET_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [ntprod_pkg::EPOCH_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [7:0]                           i_packet_byte,
    input  logic                                 i_last_byte,
    input  logic [ntprod_pkg::EPOCH_W-1:0]       i_arrival_ticks,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_status,
    output logic [1:0]                           o_leap,
    output logic [2:0]                           o_version,
    output logic [2:0]                           o_mode_code,
    output logic [1:0]                           o_stratum_class,
    output logic signed [ntprod_pkg::TICK_W-1:0] o_round_trip,
    output logic signed [ntprod_pkg::TICK_W-1:0] o_clock_offset
);

    ntprod_pkg::t_cmd w_cmd;

    ntprod_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_byte (i_last_byte),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    ntprod_dp #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_packet_byte   (i_packet_byte),
        .i_arrival_ticks (i_arrival_ticks),
        .o_status        (o_status),
        .o_leap          (o_leap),
        .o_version       (o_version),
        .o_mode_code     (o_mode_code),
        .o_stratum_class (o_stratum_class),
        .o_round_trip    (o_round_trip),
        .o_clock_offset  (o_clock_offset)
    );

endmodule

>>> test/tb.sv
// self-checking testbench for the sntp response offset and round-trip delay block
import ntprod_pkg::*;

typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         leap;
    logic [2:0]         version;
    logic [2:0]         mode_code;
    logic [1:0]         stratum_class;
    logic signed [63:0] round_trip;
    logic signed [63:0] clock_offset;
} ntp_result_t;

class ntp_offset_scoreboard;
    localparam logic [63:0] MS_PER_SEC = 64'd1000;

    logic [62:0] epoch_ticks;
    logic [19:0] ticks_per_ms;
    int unsigned byte_idx;
    logic [7:0]  hdr [2];
    logic [63:0] orig_stamp;
    logic [63:0] recv_stamp;
    logic [63:0] xmit_stamp;
    ntp_result_t pending_q [$];
    int unsigned errors;

    function new();
        epoch_ticks  = EPOCH_RESET;
        ticks_per_ms = TPM_RESET;
        byte_idx     = 0;
        hdr[0]       = '0;
        hdr[1]       = '0;
        orig_stamp   = '0;
        recv_stamp   = '0;
        xmit_stamp   = '0;
        errors       = 0;
    endfunction

    function void set_config(logic idx, logic [62:0] value);
        if (idx == CFG_EPOCH) begin
            epoch_ticks = value;
        end else begin
            ticks_per_ms = value[19:0];
        end
    endfunction

    // 32.32 stamp to local ticks, fraction of a millisecond dropped
    function logic [63:0] to_ticks(logic [63:0] stamp);
        logic [63:0] ms;
        ms = {32'd0, stamp[63:32]} * MS_PER_SEC
           + (({32'd0, stamp[31:0]} * MS_PER_SEC) >> 32);
        return {1'b0, epoch_ticks} + ms * {44'd0, ticks_per_ms};
    endfunction

    function logic [63:0] halve(logic [63:0] v);
        logic [63:0] mag;
        if (v[63]) begin
            mag = (~v + 64'd1) >> 1;
            return ~mag + 64'd1;
        end
        return v >> 1;
    endfunction

    function void note_item(logic [7:0] b, logic last, logic [62:0] arrival);
        ntp_result_t r;
        logic [63:0] o;
        logic [63:0] rv;
        logic [63:0] t;
        logic [63:0] d;
        if (byte_idx < PACKET_BYTES_DEF) begin
            if (byte_idx < 2) begin
                hdr[byte_idx] = b;
            end else if (byte_idx >= OFF_ORIGINATE && byte_idx < OFF_RECEIVE) begin
                orig_stamp = {orig_stamp[55:0], b};
            end else if (byte_idx >= OFF_RECEIVE && byte_idx < OFF_TRANSMIT) begin
                recv_stamp = {recv_stamp[55:0], b};
            end else if (byte_idx >= OFF_TRANSMIT
                         && byte_idx < OFF_TRANSMIT + STAMP_BYTES) begin
                xmit_stamp = {xmit_stamp[55:0], b};
            end
            byte_idx++;
        end
        if (!last) begin
            return;
        end
        r = '0;
        if (byte_idx < PACKET_BYTES_DEF) begin
            r.status = STAT_SHORT;
        end else begin
            r.leap      = hdr[0][7:6];
            r.version   = hdr[0][5:3];
            r.mode_code = hdr[0][2:0];
            if (hdr[1] == 8'd0) begin
                r.stratum_class = 2'd0;
            end else if (hdr[1] == 8'd1) begin
                r.stratum_class = 2'd1;
            end else if (hdr[1] <= 8'd15) begin
                r.stratum_class = 2'd2;
            end else begin
                r.stratum_class = 2'd3;
            end
            if (hdr[0][2:0] != MODE_SERVER) begin
                r.status = STAT_MODE;
            end else begin
                o  = to_ticks(orig_stamp);
                rv = to_ticks(recv_stamp);
                t  = to_ticks(xmit_stamp);
                d  = {1'b0, arrival};
                r.status       = STAT_OK;
                r.round_trip   = (d - o) - (t - rv);
                r.clock_offset = halve((rv - o) + (t - d));
            end
        end
        byte_idx = 0;
        pending_q.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check(ntp_result_t got);
        ntp_result_t want;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d",
                     $time, got.status);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        compare("status", want.status, got.status);
        compare("leap", want.leap, got.leap);
        compare("version", want.version, got.version);
        compare("mode_code", want.mode_code, got.mode_code);
        compare("stratum_class", want.stratum_class, got.stratum_class);
        compare("round_trip", want.round_trip, got.round_trip);
        compare("clock_offset", want.clock_offset, got.clock_offset);
    endfunction
endclass

module tb;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          PHASES       = 6;
    localparam int          PHASE_ITEMS  = 230;
    localparam logic [2:0]  MODE_CLIENT  = 3'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = CFG_EPOCH;
    logic [EPOCH_W-1:0] i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_packet_byte = '0;
    logic               i_last_byte = 1'b0;
    logic [EPOCH_W-1:0] i_arrival_ticks = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_status;
    logic [1:0]         o_leap;
    logic [2:0]         o_version;
    logic [2:0]         o_mode_code;
    logic [1:0]         o_stratum_class;
    logic signed [TICK_W-1:0] o_round_trip;
    logic signed [TICK_W-1:0] o_clock_offset;

    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          phase_tx_pct = 0;
    int          phase_rx_pct = 0;
    int unsigned phase_items = 0;

    ntp_offset_scoreboard sb = new;

    ntp_response_offset_delay_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_packet_byte   (i_packet_byte),
        .i_last_byte     (i_last_byte),
        .i_arrival_ticks (i_arrival_ticks),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_leap          (o_leap),
        .o_version       (o_version),
        .o_mode_code     (o_mode_code),
        .o_stratum_class (o_stratum_class),
        .o_round_trip    (o_round_trip),
        .o_clock_offset  (o_clock_offset)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check(ntp_result_t'{o_status, o_leap, o_version, o_mode_code,
                                   o_stratum_class, o_round_trip, o_clock_offset});
        end
        i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic logic [62:0] rand63();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[62:0];
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic [62:0] arrival);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_packet_byte   <= b;
        i_last_byte     <= last;
        i_arrival_ticks <= arrival;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_item(b, last, arrival);
        phase_items++;
    endtask

    task automatic send_packet(input int len, input logic [7:0] h0, input logic [7:0] h1,
                               input logic [63:0] o, input logic [63:0] r,
                               input logic [63:0] t, input logic [62:0] arrival);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            if (i == 0) begin
                b = h0;
            end else if (i == 1) begin
                b = h1;
            end else if (i >= OFF_ORIGINATE && i < OFF_RECEIVE) begin
                b = o[63 - 8 * (i - OFF_ORIGINATE) -: 8];
            end else if (i >= OFF_RECEIVE && i < OFF_TRANSMIT) begin
                b = r[63 - 8 * (i - OFF_RECEIVE) -: 8];
            end else if (i >= OFF_TRANSMIT && i < OFF_TRANSMIT + STAMP_BYTES) begin
                b = t[63 - 8 * (i - OFF_TRANSMIT) -: 8];
            end else begin
                b = 8'($urandom);
            end
            send_byte(b, i == len - 1, (i == len - 1) ? arrival : rand63());
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [62:0] epoch, input logic [19:0] tpm);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_EPOCH;
        i_cfg_data  <= epoch;
        @(posedge i_clk);
        sb.set_config(CFG_EPOCH, epoch);
        i_cfg_index <= CFG_TPM;
        i_cfg_data  <= {43'd0, tpm};
        @(posedge i_clk);
        sb.set_config(CFG_TPM, {43'd0, tpm});
        i_cfg_we    <= 1'b0;
    endtask

    task automatic random_packet();
        int          len;
        int          pick;
        logic [7:0]  h0;
        logic [7:0]  h1;
        logic [63:0] o;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] skew;
        logic [63:0] tick_d;
        logic [62:0] arrival;
        tx_idle_pct  = ($urandom_range(4) == 0) ? 0 : phase_tx_pct;
        rx_stall_pct = ($urandom_range(4) == 0) ? 0 : phase_rx_pct;
        pick = $urandom_range(99);
        if (pick < 80) begin
            len = PACKET_BYTES_DEF;
        end else if (pick < 90) begin
            len = $urandom_range(63, PACKET_BYTES_DEF + 1);
        end else begin
            len = $urandom_range(PACKET_BYTES_DEF - 1, 1);
        end
        h0 = 8'($urandom);
        if ($urandom_range(3) != 0) begin
            h0[2:0] = MODE_SERVER;
        end
        case ($urandom_range(4))
            0: h1 = 8'd0;
            1: h1 = 8'd1;
            2: h1 = 8'($urandom_range(15, 2));
            3: h1 = 8'($urandom_range(255, 16));
            default: h1 = 8'($urandom);
        endcase
        if ($urandom_range(9) < 6) begin
            // plausible exchange: small skew and a short turnaround
            o    = {$urandom, $urandom};
            skew = {28'd0, $urandom, 4'd0};
            r    = $urandom_range(1) ? o + skew : o - skew;
            t    = r + 64'($urandom_range(1 << 28));
            tick_d = sb.to_ticks(o) + (sb.to_ticks(t) - sb.to_ticks(r))
                   + 64'($urandom_range(1000000));
            arrival = tick_d[62:0];
        end else begin
            o = {$urandom, $urandom};
            r = {$urandom, $urandom};
            t = {$urandom, $urandom};
            arrival = rand63();
        end
        if ($urandom_range(19) == 0) begin
            drain();
        end
        send_packet(len, h0, h1, o, r, t, arrival);
    endtask

    initial begin
        logic [63:0] o;
        logic [62:0] arrival;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_packet(1, 8'h24, 8'd1, '0, '0, '0, '1);
        send_packet(PACKET_BYTES_DEF - 1, {2'd0, 3'd4, MODE_SERVER}, 8'd2, '1, '1, '1, '0);
        send_packet(PACKET_BYTES_DEF, {2'd0, 3'd4, MODE_SERVER}, 8'd0, '0, '0, '0, '0);
        send_packet(PACKET_BYTES_DEF, {2'd3, 3'd7, MODE_SERVER}, 8'd1, '1, '1, '1, '1);
        send_packet(PACKET_BYTES_DEF, {2'd1, 3'd3, MODE_CLIENT}, 8'd15, '1, '0, '1, '1);
        o = {32'hE000_0000, 32'h8000_0000};
        arrival = 63'(sb.to_ticks(o) + 64'd5000000);
        send_packet(60, {2'd2, 3'd4, MODE_SERVER}, 8'd16, o, o + 64'h1_0000_0000,
                    o + 64'h1_4000_0000, arrival);
        send_packet(PACKET_BYTES_DEF, {2'd0, 3'd4, MODE_SERVER}, 8'd255, o,
                    o - 64'h5_0000_0000, o - 64'h4_FFFF_0000, arrival);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin phase_tx_pct = 0;  phase_rx_pct = 0;  end
                1: begin phase_tx_pct = 84; phase_rx_pct = 0;  end
                2: begin phase_tx_pct = 0;  phase_rx_pct = 84; end
                default: begin phase_tx_pct = 37; phase_rx_pct = 37; end
            endcase
            if (phase != 0) begin
                drain();
                case (phase)
                    1: configure('0, 20'd1);
                    2: configure('1, 20'd1000000);
                    4: configure(EPOCH_RESET, 20'd1000);
                    default: configure(rand63(), 20'($urandom_range(1000000, 1)));
                endcase
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) random_packet();
        end

        drain();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end
endmodule

>>> files.f
design/ntprod_pkg.sv
design/ntprod_ctrl.sv
design/ntprod_dp.sv
design/ntp_response_offset_delay_top.sv
test/tb.sv
